/* rtl/hcbg_pkg.sv */
`default_nettype none
package hcbg_pkg;

   localparam int MaxRequestBytes = 64;
   localparam int SeedWords       = 8;
   localparam int CsrIndexWidth   = 3;
   localparam int CsrDataWidth    = 64;
   localparam int ReqBytesWidth   = 7;
   localparam int CmdDepth        = 2;

   typedef logic [63:0] word_type;
   typedef logic [511:0] chain_type;

   typedef struct packed {
      logic                     reload;
      logic [ReqBytesWidth-1:0] count;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINAL,
      ST_EMIT
   } state_type;

   function automatic word_type round_k(input logic [6:0] i);
      word_type k;
      case (i)
         7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
         7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
         7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
         7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
         7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
         7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
         7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
         7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
         7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
         7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
         7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
         7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
         7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
         7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
         7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
         7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
         7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
         7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
         7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
         7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
         7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
         7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
         7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
         7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
         7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
         7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
         7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
         7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
         7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
         7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
         7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
         7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
         7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
         7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
         7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
         7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
         7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
         7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
         7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
         7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
         default: k = '0;
      endcase
      return k;
   endfunction

   localparam chain_type InitH = {
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
      64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (64 - n));
   endfunction

endpackage
`default_nettype wire

/* rtl/hcbg_front.sv */
`default_nettype none
// Accepts requests, saturates the count, queues them for the back end.
module hcbg_front #(
   parameter int MAX_REQUEST_BYTES = hcbg_pkg::MaxRequestBytes
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 push,
   output logic                                      full,
   input  wire logic                                 req_reload_seed,
   input  wire logic [hcbg_pkg::ReqBytesWidth-1:0]   req_request_bytes,
   output logic                                      cmd_valid,
   output hcbg_pkg::cmd_type                         cmd,
   input  wire logic                                 cmd_take
);
   localparam logic [hcbg_pkg::ReqBytesWidth-1:0] MaxCount =
      hcbg_pkg::ReqBytesWidth'(MAX_REQUEST_BYTES);

   hcbg_pkg::cmd_type q_ff [hcbg_pkg::CmdDepth];
   hcbg_pkg::cmd_type entry;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   always_comb begin
      entry.reload = req_reload_seed;
      entry.count  = (req_request_bytes > MaxCount) ? MaxCount : req_request_bytes;
   end

   assign full      = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> cnt_ff == 2'd2) else $error("queue count bad");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("push lost");
   a_sat: assert property (@(posedge clock) disable iff (reset)
      cmd_valid |-> cmd.count <= MaxCount) else $error("count not saturated");
endmodule
`default_nettype wire

/* rtl/hcbg_back.sv */
`default_nettype none
// One SHA-512 round per cycle, then one byte per beat out of a one-entry
// output register.
module hcbg_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                cmd_valid,
   input  wire hcbg_pkg::cmd_type                   cmd,
   output logic                                     cmd_take,
   input  wire hcbg_pkg::chain_type                 seed,
   output logic                                     empty,
   input  wire logic                                pop,
   output logic [7:0]                               rsp_data_byte,
   output logic                                     rsp_last_byte
);
   typedef hcbg_pkg::word_type word_t_type;

   hcbg_pkg::state_type state_ff, state_in;
   hcbg_pkg::chain_type chain_ff, chain_in;
   word_t_type v_ff [8];
   word_t_type v_in [8];
   word_t_type w_ff [16];
   word_t_type w_in [16];
   logic [6:0] rnd_ff, rnd_in;
   logic [6:0] total_ff, total_in;
   logic [6:0] idx_ff, idx_in;
   logic       ovalid_ff, ovalid_in;
   logic [7:0] obyte_ff, obyte_in;
   logic       olast_ff, olast_in;

   hcbg_pkg::chain_type start_chain;
   word_t_type t1, t2, s0, s1, wnew, e, a;
   logic       slot_free, zero_cmd;

   assign start_chain = cmd.reload ? seed : chain_ff;
   assign zero_cmd    = (cmd.count == 7'd0);
   assign slot_free   = !ovalid_ff || pop;

   always_comb begin
      e  = v_ff[4];
      a  = v_ff[0];
      t1 = v_ff[7] + (hcbg_pkg::rotr(e, 14) ^ hcbg_pkg::rotr(e, 18) ^ hcbg_pkg::rotr(e, 41))
         + ((e & v_ff[5]) ^ (~e & v_ff[6])) + hcbg_pkg::round_k(rnd_ff) + w_ff[0];
      t2 = (hcbg_pkg::rotr(a, 28) ^ hcbg_pkg::rotr(a, 34) ^ hcbg_pkg::rotr(a, 39))
         + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      s0 = hcbg_pkg::rotr(w_ff[1], 1) ^ hcbg_pkg::rotr(w_ff[1], 8) ^ (w_ff[1] >> 7);
      s1 = hcbg_pkg::rotr(w_ff[14], 19) ^ hcbg_pkg::rotr(w_ff[14], 61) ^ (w_ff[14] >> 6);
      wnew = w_ff[0] + s0 + w_ff[9] + s1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hcbg_pkg::ST_IDLE:  if (cmd_valid && !zero_cmd) state_in = hcbg_pkg::ST_ROUND;
         hcbg_pkg::ST_ROUND: if (rnd_ff == 7'd79) state_in = hcbg_pkg::ST_FINAL;
         hcbg_pkg::ST_FINAL: state_in = hcbg_pkg::ST_EMIT;
         hcbg_pkg::ST_EMIT:  if (slot_free && idx_ff + 7'd1 == total_ff)
                                state_in = hcbg_pkg::ST_IDLE;
         default:            state_in = hcbg_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      chain_in  = chain_ff;
      v_in      = v_ff;
      w_in      = w_ff;
      rnd_in    = rnd_ff;
      total_in  = total_ff;
      idx_in    = idx_ff;
      ovalid_in = ovalid_ff && !pop;
      obyte_in  = obyte_ff;
      olast_in  = olast_ff;
      cmd_take  = 1'b0;
      case (state_ff)
         hcbg_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               chain_in = start_chain;
               total_in = cmd.count;
               rnd_in   = 7'd0;
               idx_in   = 7'd0;
               for (int i = 0; i < 8; i++) begin
                  v_in[i] = hcbg_pkg::InitH[511-64*i -: 64];
                  w_in[i] = start_chain[511-64*i -: 64];
               end
               w_in[8] = 64'h8000000000000000;
               for (int i = 9; i < 15; i++) w_in[i] = '0;
               w_in[15] = 64'd512;
            end
         end
         hcbg_pkg::ST_ROUND: begin
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = e;
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = a;
            v_in[0] = t1 + t2;
            for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
            w_in[15] = wnew;
            rnd_in   = rnd_ff + 7'd1;
         end
         hcbg_pkg::ST_FINAL: begin
            for (int i = 0; i < 8; i++)
               chain_in[511-64*i -: 64] = hcbg_pkg::InitH[511-64*i -: 64] + v_ff[i];
         end
         hcbg_pkg::ST_EMIT: begin
            if (slot_free) begin
               ovalid_in = 1'b1;
               obyte_in  = chain_ff[511 - 8*idx_ff[5:0] -: 8];
               olast_in  = (idx_ff + 7'd1 == total_ff);
               idx_in    = idx_ff + 7'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      v_ff     <= v_in;
      w_ff     <= w_in;
      total_ff <= total_in;
      obyte_ff <= obyte_in;
      olast_ff <= olast_in;
      rnd_ff   <= rnd_in;
      idx_ff   <= idx_in;
      if (reset) begin
         state_ff  <= hcbg_pkg::ST_IDLE;
         chain_ff  <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         chain_ff  <= chain_in;
         ovalid_ff <= ovalid_in;
      end
   end

   assign empty         = !ovalid_ff;
   assign rsp_data_byte = obyte_ff;
   assign rsp_last_byte = olast_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && !pop) |=> ovalid_ff && $stable(obyte_ff)) else $error("beat dropped");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> state_ff == hcbg_pkg::ST_IDLE) else $error("take while busy");
   a_rounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == hcbg_pkg::ST_FINAL |-> rnd_ff == 7'd80) else $error("round count");
endmodule
`default_nettype wire

/* rtl/hash_chain_byte_generator.sv */
`default_nettype none
// Hash-chain byte generator. Each nonzero request replaces the 512-bit chain
// by the SHA-512 digest of itself (optionally reloaded from the seed
// registers first) and returns the first N digest bytes, last one flagged.
// A request is launched from the idle state, runs 80 rounds of the single round
// unit, folds the digest into the chain, then emits one byte per cycle while pop
// keeps up. A two-entry request queue lets push run ahead.
// Zero-byte requests only apply the reload. Seed registers should only be
// written while no request is pending.
module hash_chain_byte_generator #(
   parameter int MAX_REQUEST_BYTES = hcbg_pkg::MaxRequestBytes
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                push,
   output logic                                     full,
   input  wire logic                                req_reload_seed,
   input  wire logic [hcbg_pkg::ReqBytesWidth-1:0]  req_request_bytes,
   output logic                                     empty,
   input  wire logic                                pop,
   output logic [7:0]                               rsp_data_byte,
   output logic                                     rsp_last_byte,
   input  wire logic                                csr_write,
   input  wire logic [hcbg_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [hcbg_pkg::CsrDataWidth-1:0]   csr_data
);
   hcbg_pkg::chain_type seed_ff;
   hcbg_pkg::cmd_type   cmd;
   logic                cmd_valid, cmd_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_write) begin
         seed_ff[511 - 64*csr_index -: 64] <= csr_data;
      end
   end

   hcbg_front #(.MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)) u_front (
      .clock, .reset, .push, .full, .req_reload_seed, .req_request_bytes,
      .cmd_valid, .cmd, .cmd_take);

   hcbg_back u_back (
      .clock, .reset, .cmd_valid, .cmd, .cmd_take, .seed(seed_ff),
      .empty, .pop, .rsp_data_byte, .rsp_last_byte);
endmodule
`default_nettype wire
